// ===== hw/rtl/ecsg_pkg.sv =====
package ecsg_pkg;

    localparam int FIELD_BITS = 31;
    localparam int CNT_W = $clog2(FIELD_BITS);
    localparam int EXP_BITS = 32;

    localparam logic [1:0] CFG_CURVE_A = 2'd0;
    localparam logic [1:0] CFG_CURVE_P = 2'd1;
    localparam logic [1:0] CFG_GROUP_Q = 2'd2;

    localparam logic [FIELD_BITS-1:0] RST_CURVE_A = FIELD_BITS'(1);
    localparam logic [FIELD_BITS-1:0] RST_CURVE_P = FIELD_BITS'(11);
    localparam logic [FIELD_BITS-1:0] RST_GROUP_Q = FIELD_BITS'(13);
    localparam logic [FIELD_BITS-1:0] MIN_P = FIELD_BITS'(3);
    localparam logic [FIELD_BITS-1:0] MIN_Q = FIELD_BITS'(2);

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_RED_A, OP_RED_X, OP_RED_Y, OP_SET_INF,
        OP_DBL_SQ, OP_DBL_3, OP_DBL_NUM, OP_DBL_2Y, OP_INV_INIT, OP_INV_DIV,
        OP_INV_END, OP_SLOPE, OP_FS_SQ, OP_FS_X, OP_FS_DX, OP_FS_MUL, OP_FS_Y,
        OP_ADD_BASE, OP_ADD_NUM, OP_BIT_NEXT, OP_R_RED, OP_H_MUL, OP_H_SQ,
        OP_K_RED, OP_MR, OP_SUM, OP_S_MUL, OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RED_A, ST_RED_X, ST_RED_Y, ST_DBL_CHK, ST_DBL_SQ, ST_DBL_3,
        ST_DBL_NUM, ST_DBL_2Y, ST_INV_INIT, ST_INV_CHK, ST_INV_DIV, ST_INV_END,
        ST_SLOPE, ST_FS_SQ, ST_FS_X, ST_FS_DX, ST_FS_MUL, ST_FS_Y, ST_ADD_CHK,
        ST_ADD_NUM, ST_BIT_NEXT, ST_R_RED, ST_H_CHK, ST_H_MUL, ST_H_SQ,
        ST_K_RED, ST_MR, ST_SUM, ST_S_MUL, ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   start;
        logic   capture;
        logic   use_q;
        logic   x2_base;
    } dp_cmd_t;

    typedef struct packed {
        logic alu_done;
        logic acc_inf;
        logic ay_zero;
        logic eq_x;
        logic eq_y;
        logic r1_zero;
        logic e_zero;
        logic e_lsb;
        logic kbit;
        logic idx_zero;
    } dp_status_t;

    typedef struct packed {
        logic                  start;
        logic                  div_mode;
        logic [FIELD_BITS-1:0] n;
        logic [FIELD_BITS-1:0] d;
        logic [FIELD_BITS-1:0] tx;
        logic [FIELD_BITS-1:0] m;
    } alu_req_t;

    typedef struct packed {
        logic                  done;
        logic [FIELD_BITS-1:0] rem;
        logic [FIELD_BITS-1:0] tacc;
    } alu_rsp_t;

endpackage

// ===== hw/rtl/ecsg_alu.sv =====
module ecsg_alu import ecsg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    localparam int W = FIELD_BITS;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg, div_next;
    logic [W-1:0]     n_reg, n_next;
    logic [W-1:0]     d_reg, d_next;
    logic [W-1:0]     tx_reg, tx_next;
    logic [W-1:0]     m_reg, m_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     tacc_reg, tacc_next;

    logic [W:0] rem_sh, rem_sub, t2, t2r, ta, tr;
    logic       ge, qbit;

    always_comb begin
        rem_sh = {rem_reg, n_reg[W-1]};
        ge = rem_sh >= {1'b0, d_reg};
        rem_sub = rem_sh - {1'b0, d_reg};
        qbit = div_reg ? ge : n_reg[W-1];
        t2 = {tacc_reg, 1'b0};
        t2r = (t2 >= {1'b0, m_reg}) ? t2 - {1'b0, m_reg} : t2;
        ta = t2r + (qbit ? {1'b0, tx_reg} : '0);
        tr = (ta >= {1'b0, m_reg}) ? ta - {1'b0, m_reg} : ta;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        div_next = div_reg;
        n_next = n_reg;
        d_next = d_reg;
        tx_next = tx_reg;
        m_next = m_reg;
        rem_next = rem_reg;
        tacc_next = tacc_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(W - 1);
            div_next = req.div_mode;
            n_next = req.n;
            d_next = req.d;
            tx_next = req.tx;
            m_next = req.m;
            rem_next = '0;
            tacc_next = '0;
        end else if (busy_reg) begin
            n_next = {n_reg[W-2:0], 1'b0};
            rem_next = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
            tacc_next = tr[W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        n_reg <= n_next;
        d_reg <= d_next;
        tx_reg <= tx_next;
        m_reg <= m_next;
        rem_reg <= rem_next;
        tacc_reg <= tacc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem = rem_reg;
    assign rsp.tacc = tacc_reg;

endmodule

// ===== hw/rtl/ecsg_datapath.sv =====
module ecsg_datapath import ecsg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [FIELD_BITS-1:0] curve_a,
    input  logic [FIELD_BITS-1:0] curve_p,
    input  logic [FIELD_BITS-1:0] group_order_q,
    input  logic [FIELD_BITS-1:0] base_x,
    input  logic [FIELD_BITS-1:0] base_y,
    input  logic [FIELD_BITS-1:0] message,
    input  logic [EXP_BITS-1:0]   hash_exponent,
    input  logic [FIELD_BITS-1:0] nonce,
    output logic [FIELD_BITS-1:0] sig_r,
    output logic [FIELD_BITS-1:0] sig_s,
    output logic                  error
);

    localparam int W = FIELD_BITS;

    function automatic logic [W-1:0] msub(logic [W-1:0] x, logic [W-1:0] y,
                                          logic [W-1:0] m);
        logic [W:0] d;
        d = {1'b0, x} - {1'b0, y};
        if (d[W]) begin
            d = d + {1'b0, m};
        end
        return d[W-1:0];
    endfunction

    function automatic logic [W-1:0] madd(logic [W-1:0] x, logic [W-1:0] y,
                                          logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    logic [W-1:0] p_reg, q_reg, a_reg, bx_reg, by_reg, ax_reg, ay_reg;
    logic [W-1:0] msg_reg, k_reg, num_reg, tmp_reg, nx_reg, lam_reg, inv_v_reg;
    logic [W-1:0] r0_reg, r1_reg, t0_reg, t1_reg, inv_res_reg, h_reg, b2_reg;
    logic [W-1:0] r_reg, sig_r_reg, sig_s_reg;
    logic [EXP_BITS-1:0] e_reg;
    logic [CNT_W-1:0] idx_reg;
    logic inf_reg, inv_ok_reg, error_reg;

    logic [W-1:0] p_sat, q_sat, mod_inv, x2;
    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    ecsg_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    assign p_sat = (curve_p < MIN_P) ? MIN_P : curve_p;
    assign q_sat = (group_order_q < MIN_Q) ? MIN_Q : group_order_q;
    assign mod_inv = cmd.use_q ? q_reg : p_reg;
    assign x2 = cmd.x2_base ? bx_reg : ax_reg;

    always_comb begin
        alu_req.start = cmd.start;
        alu_req.div_mode = 1'b0;
        alu_req.n = '0;
        alu_req.d = r1_reg;
        alu_req.tx = W'(1);
        alu_req.m = p_reg;
        case (cmd.op)
            OP_RED_A: alu_req.n = curve_a;
            OP_RED_X: alu_req.n = bx_reg;
            OP_RED_Y: alu_req.n = by_reg;
            OP_DBL_SQ: begin
                alu_req.tx = ax_reg;
                alu_req.n = ax_reg;
            end
            OP_DBL_3: begin
                alu_req.tx = tmp_reg;
                alu_req.n = W'(3);
            end
            OP_DBL_2Y: begin
                alu_req.tx = ay_reg;
                alu_req.n = W'(2);
            end
            OP_INV_DIV: begin
                alu_req.div_mode = 1'b1;
                alu_req.n = r0_reg;
                alu_req.tx = t1_reg;
                alu_req.m = mod_inv;
            end
            OP_SLOPE: begin
                alu_req.tx = num_reg;
                alu_req.n = inv_res_reg;
            end
            OP_FS_SQ: begin
                alu_req.tx = lam_reg;
                alu_req.n = lam_reg;
            end
            OP_FS_MUL: begin
                alu_req.tx = lam_reg;
                alu_req.n = tmp_reg;
            end
            OP_R_RED: begin
                alu_req.n = inf_reg ? '0 : ax_reg;
                alu_req.m = q_reg;
            end
            OP_H_MUL: begin
                alu_req.tx = h_reg;
                alu_req.n = b2_reg;
                alu_req.m = q_reg;
            end
            OP_H_SQ: begin
                alu_req.tx = b2_reg;
                alu_req.n = b2_reg;
                alu_req.m = q_reg;
            end
            OP_K_RED: begin
                alu_req.n = k_reg;
                alu_req.m = q_reg;
            end
            OP_MR: begin
                alu_req.tx = r_reg;
                alu_req.n = msg_reg;
                alu_req.m = q_reg;
            end
            OP_S_MUL: begin
                alu_req.tx = tmp_reg;
                alu_req.n = inv_res_reg;
                alu_req.m = q_reg;
            end
            default: alu_req.n = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                p_reg <= p_sat;
                q_reg <= q_sat;
                bx_reg <= base_x;
                by_reg <= base_y;
                msg_reg <= message;
                e_reg <= hash_exponent;
                k_reg <= nonce;
                inf_reg <= 1'b1;
                idx_reg <= CNT_W'(W - 1);
                h_reg <= W'(1);
                b2_reg <= (q_sat == MIN_Q) ? '0 : W'(2);
            end
            OP_RED_A: if (cmd.capture) a_reg <= alu_rsp.tacc;
            OP_RED_X: if (cmd.capture) bx_reg <= alu_rsp.tacc;
            OP_RED_Y: if (cmd.capture) by_reg <= alu_rsp.tacc;
            OP_SET_INF: inf_reg <= 1'b1;
            OP_DBL_SQ, OP_DBL_3, OP_FS_SQ, OP_FS_MUL, OP_MR, OP_S_MUL: begin
                if (cmd.capture) tmp_reg <= alu_rsp.tacc;
            end
            OP_DBL_NUM: num_reg <= madd(tmp_reg, a_reg, p_reg);
            OP_DBL_2Y, OP_K_RED: if (cmd.capture) inv_v_reg <= alu_rsp.tacc;
            OP_INV_INIT: begin
                r0_reg <= mod_inv;
                r1_reg <= inv_v_reg;
                t0_reg <= '0;
                t1_reg <= W'(1);
            end
            OP_INV_DIV: begin
                if (cmd.capture) begin
                    r0_reg <= r1_reg;
                    r1_reg <= alu_rsp.rem;
                    t0_reg <= t1_reg;
                    t1_reg <= msub(t0_reg, alu_rsp.tacc, mod_inv);
                end
            end
            OP_INV_END: begin
                inv_ok_reg <= (r0_reg == W'(1));
                inv_res_reg <= (r0_reg == W'(1)) ? t0_reg : '0;
            end
            OP_SLOPE: if (cmd.capture) lam_reg <= alu_rsp.tacc;
            OP_FS_X: nx_reg <= msub(msub(tmp_reg, ax_reg, p_reg), x2, p_reg);
            OP_FS_DX: tmp_reg <= msub(ax_reg, nx_reg, p_reg);
            OP_FS_Y: begin
                ay_reg <= msub(tmp_reg, ay_reg, p_reg);
                ax_reg <= nx_reg;
                inf_reg <= 1'b0;
            end
            OP_ADD_BASE: begin
                ax_reg <= bx_reg;
                ay_reg <= by_reg;
                inf_reg <= 1'b0;
            end
            OP_ADD_NUM: begin
                num_reg <= msub(by_reg, ay_reg, p_reg);
                inv_v_reg <= msub(bx_reg, ax_reg, p_reg);
            end
            OP_BIT_NEXT: idx_reg <= idx_reg - CNT_W'(1);
            OP_R_RED: if (cmd.capture) r_reg <= alu_rsp.tacc;
            OP_H_MUL: if (cmd.capture) h_reg <= alu_rsp.tacc;
            OP_H_SQ: begin
                if (cmd.capture) begin
                    b2_reg <= alu_rsp.tacc;
                    e_reg <= {1'b0, e_reg[EXP_BITS-1:1]};
                end
            end
            OP_SUM: tmp_reg <= madd(h_reg, tmp_reg, q_reg);
            OP_OUT: begin
                sig_r_reg <= r_reg;
                sig_s_reg <= tmp_reg;
                error_reg <= !inv_ok_reg;
            end
            default: inf_reg <= inf_reg;
        endcase
    end

    assign status.alu_done = alu_rsp.done;
    assign status.acc_inf = inf_reg;
    assign status.ay_zero = (ay_reg == '0);
    assign status.eq_x = (ax_reg == bx_reg);
    assign status.eq_y = (ay_reg == by_reg);
    assign status.r1_zero = (r1_reg == '0);
    assign status.e_zero = (e_reg == '0);
    assign status.e_lsb = e_reg[0];
    assign status.kbit = k_reg[idx_reg];
    assign status.idx_zero = (idx_reg == '0);

    assign sig_r = sig_r_reg;
    assign sig_s = sig_s_reg;
    assign error = error_reg;

endmodule

// ===== hw/rtl/ecsg_ctrl.sv =====
module ecsg_ctrl import ecsg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next, alu_adv;
    logic busy_reg, busy_next;
    logic phase_reg, phase_next;
    logic use_q_reg, use_q_next;
    logic x2_base_reg, x2_base_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic alu_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            busy_reg <= 1'b0;
            phase_reg <= 1'b0;
            use_q_reg <= 1'b0;
            x2_base_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg <= busy_next;
            phase_reg <= phase_next;
            use_q_reg <= use_q_next;
            x2_base_reg <= x2_base_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        busy_next = busy_reg;
        phase_next = phase_reg;
        use_q_next = use_q_reg;
        x2_base_next = x2_base_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        alu_step = 1'b0;
        alu_adv = state_reg;
        s_tready = 1'b0;
        cmd.op = OP_NONE;
        cmd.start = 1'b0;
        cmd.capture = 1'b0;
        cmd.use_q = use_q_reg;
        cmd.x2_base = x2_base_reg;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                    phase_next = 1'b0;
                    use_q_next = 1'b0;
                    x2_base_next = 1'b0;
                    state_next = ST_RED_A;
                end
            end
            ST_RED_A: begin
                cmd.op = OP_RED_A;
                alu_step = 1'b1;
                alu_adv = ST_RED_X;
            end
            ST_RED_X: begin
                cmd.op = OP_RED_X;
                alu_step = 1'b1;
                alu_adv = ST_RED_Y;
            end
            ST_RED_Y: begin
                cmd.op = OP_RED_Y;
                alu_step = 1'b1;
                alu_adv = ST_DBL_CHK;
            end
            ST_DBL_CHK: begin
                x2_base_next = 1'b0;
                if (status.acc_inf || status.ay_zero) begin
                    cmd.op = OP_SET_INF;
                    if (!phase_reg && status.kbit) begin
                        phase_next = 1'b1;
                        state_next = ST_ADD_CHK;
                    end else begin
                        state_next = ST_BIT_NEXT;
                    end
                end else begin
                    state_next = ST_DBL_SQ;
                end
            end
            ST_DBL_SQ: begin
                cmd.op = OP_DBL_SQ;
                alu_step = 1'b1;
                alu_adv = ST_DBL_3;
            end
            ST_DBL_3: begin
                cmd.op = OP_DBL_3;
                alu_step = 1'b1;
                alu_adv = ST_DBL_NUM;
            end
            ST_DBL_NUM: begin
                cmd.op = OP_DBL_NUM;
                state_next = ST_DBL_2Y;
            end
            ST_DBL_2Y: begin
                cmd.op = OP_DBL_2Y;
                alu_step = 1'b1;
                alu_adv = ST_INV_INIT;
            end
            ST_INV_INIT: begin
                cmd.op = OP_INV_INIT;
                state_next = ST_INV_CHK;
            end
            ST_INV_CHK: begin
                state_next = status.r1_zero ? ST_INV_END : ST_INV_DIV;
            end
            ST_INV_DIV: begin
                cmd.op = OP_INV_DIV;
                alu_step = 1'b1;
                alu_adv = ST_INV_CHK;
            end
            ST_INV_END: begin
                cmd.op = OP_INV_END;
                state_next = use_q_reg ? ST_MR : ST_SLOPE;
            end
            ST_SLOPE: begin
                cmd.op = OP_SLOPE;
                alu_step = 1'b1;
                alu_adv = ST_FS_SQ;
            end
            ST_FS_SQ: begin
                cmd.op = OP_FS_SQ;
                alu_step = 1'b1;
                alu_adv = ST_FS_X;
            end
            ST_FS_X: begin
                cmd.op = OP_FS_X;
                state_next = ST_FS_DX;
            end
            ST_FS_DX: begin
                cmd.op = OP_FS_DX;
                state_next = ST_FS_MUL;
            end
            ST_FS_MUL: begin
                cmd.op = OP_FS_MUL;
                alu_step = 1'b1;
                alu_adv = ST_FS_Y;
            end
            ST_FS_Y: begin
                cmd.op = OP_FS_Y;
                if (!phase_reg && status.kbit) begin
                    phase_next = 1'b1;
                    state_next = ST_ADD_CHK;
                end else begin
                    state_next = ST_BIT_NEXT;
                end
            end
            ST_ADD_CHK: begin
                if (status.acc_inf) begin
                    cmd.op = OP_ADD_BASE;
                    state_next = ST_BIT_NEXT;
                end else if (status.eq_x && status.eq_y) begin
                    state_next = ST_DBL_CHK;
                end else if (status.eq_x) begin
                    cmd.op = OP_SET_INF;
                    state_next = ST_BIT_NEXT;
                end else begin
                    state_next = ST_ADD_NUM;
                end
            end
            ST_ADD_NUM: begin
                cmd.op = OP_ADD_NUM;
                x2_base_next = 1'b1;
                state_next = ST_INV_INIT;
            end
            ST_BIT_NEXT: begin
                if (status.idx_zero) begin
                    state_next = ST_R_RED;
                end else begin
                    cmd.op = OP_BIT_NEXT;
                    phase_next = 1'b0;
                    state_next = ST_DBL_CHK;
                end
            end
            ST_R_RED: begin
                cmd.op = OP_R_RED;
                alu_step = 1'b1;
                alu_adv = ST_H_CHK;
            end
            ST_H_CHK: begin
                if (status.e_zero) begin
                    state_next = ST_K_RED;
                end else if (status.e_lsb) begin
                    state_next = ST_H_MUL;
                end else begin
                    state_next = ST_H_SQ;
                end
            end
            ST_H_MUL: begin
                cmd.op = OP_H_MUL;
                alu_step = 1'b1;
                alu_adv = ST_H_SQ;
            end
            ST_H_SQ: begin
                cmd.op = OP_H_SQ;
                alu_step = 1'b1;
                alu_adv = ST_H_CHK;
            end
            ST_K_RED: begin
                cmd.op = OP_K_RED;
                cmd.use_q = 1'b1;
                use_q_next = 1'b1;
                alu_step = 1'b1;
                alu_adv = ST_INV_INIT;
            end
            ST_MR: begin
                cmd.op = OP_MR;
                alu_step = 1'b1;
                alu_adv = ST_SUM;
            end
            ST_SUM: begin
                cmd.op = OP_SUM;
                state_next = ST_S_MUL;
            end
            ST_S_MUL: begin
                cmd.op = OP_S_MUL;
                alu_step = 1'b1;
                alu_adv = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op = OP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (alu_step) begin
            cmd.start = !busy_reg;
            if (!busy_reg) begin
                busy_next = 1'b1;
            end else if (status.alu_done) begin
                cmd.capture = 1'b1;
                busy_next = 1'b0;
                state_next = alu_adv;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hw/rtl/ecdsa_sign_small_prime_curve.sv =====
// Signs one request per transfer on a short Weierstrass curve over GF(p): it forms kA by
// left-to-right double-and-add over all 31 nonce bits, then r = x(kA) mod q and
// s = k^-1 * (2^e mod q + m*r) mod q, flagging error (with s = 0) when k has no
// inverse mod q. One request is in flight at a time; the finished result sits in an
// output register so the next request can be taken while it waits. Every modular
// multiply, reduction and extended-Euclid step runs through one shared bit-serial
// unit; additions and subtractions mod p or q are done directly in the datapath.
// A modular inverse is a run of such Euclid steps, and 31-bit moduli need at most 44.
module ecdsa_sign_small_prime_curve import ecsg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // base_x[30:0], base_y[61:31], message[92:62], hash_exponent[124:93],
    // nonce[155:125], zero fill
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sig_r[30:0], sig_s[61:31], zero fill
    output logic [63:0]  m_tdata,
    // error[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [FIELD_BITS-1:0] cfg_data
);

    localparam int W = FIELD_BITS;

    logic [W-1:0] curve_a_reg, curve_p_reg, group_q_reg;
    logic [W-1:0] sig_r, sig_s;
    logic         error;
    dp_cmd_t      cmd;
    dp_status_t   status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_a_reg <= RST_CURVE_A;
            curve_p_reg <= RST_CURVE_P;
            group_q_reg <= RST_GROUP_Q;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CURVE_A: curve_a_reg <= cfg_data;
                CFG_CURVE_P: curve_p_reg <= cfg_data;
                CFG_GROUP_Q: group_q_reg <= cfg_data;
                default: curve_a_reg <= curve_a_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    ecsg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ecsg_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .curve_a       (curve_a_reg),
        .curve_p       (curve_p_reg),
        .group_order_q (group_q_reg),
        .base_x        (s_tdata[30:0]),
        .base_y        (s_tdata[61:31]),
        .message       (s_tdata[92:62]),
        .hash_exponent (s_tdata[124:93]),
        .nonce         (s_tdata[155:125]),
        .sig_r         (sig_r),
        .sig_s         (sig_s),
        .error         (error)
    );

    assign m_tdata = {2'b00, sig_s, sig_r};
    assign m_tuser = error;

endmodule

// ===== hw/rtl/ecsg_checker.sv =====
module ecsg_checker import ecsg_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [159:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [0:0]   m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [1:0]   cfg_index,
    input logic [FIELD_BITS-1:0] cfg_data
);

    // A stalled result keeps its contents until the transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_err_zero_s: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[61:31] == '0)
        else $error("sig_s nonzero with error set");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

endmodule

bind ecdsa_sign_small_prime_curve ecsg_checker u_ecsg_checker (.*);
